>>> design/spem_pkg.sv
// Shared constants and types for the Sobel/Prewitt edge magnitude block.
// Used by the line store, the top level and the port checker.
`default_nettype none

package spem_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int PIX_W      = 8;
	localparam int COORD_W    = 11;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = COORD_W;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 2;

	// width able to hold a clamped image width or height
	localparam int WDIM_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	localparam int HDIM_W = ROW_W + 1;

	// signed gradient: 4 * 255 fits in PIX_W + 2 magnitude bits plus sign
	localparam int GRAD_W = PIX_W + 3;
	localparam int MAG_W  = PIX_W + 3;
	localparam int EDGE_MAX = 255;

	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;

	localparam int OUT_TDATA_W = ((PIX_W + 2 * COORD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - PIX_W - 2 * COORD_W;

	// output tdata field positions
	localparam int EDGE_LSB = 0;
	localparam int ROW_LSB  = PIX_W;
	localparam int COL_LSB  = PIX_W + COORD_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EDGE_MODE    = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
	} ls_rd_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] middle;
	} ls_wr_t;

endpackage

`default_nettype wire

>>> design/spem_line_store.sv
// Upper and middle line stores: two single-port-write memories with a
// registered read. Depends on spem_pkg for widths and request structs.
`default_nettype none

module spem_line_store
	import spem_pkg::*;
(
	input  wire logic             clk,
	input  wire ls_rd_t           rd,
	input  wire ls_wr_t           wr,
	output logic      [PIX_W-1:0] rd_upper,
	output logic      [PIX_W-1:0] rd_middle
);

	logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_upper_q;
	logic [PIX_W-1:0] rd_middle_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			upper_mem[wr.addr]  <= wr.upper;
			middle_mem[wr.addr] <= wr.middle;
		end
	end

	// forward a same-edge write to the same column
	always_ff @(posedge clk) begin
		if (rd.en) begin
			if (wr.en && (wr.addr == rd.addr)) begin
				rd_upper_q  <= wr.upper;
				rd_middle_q <= wr.middle;
			end else begin
				rd_upper_q  <= upper_mem[rd.addr];
				rd_middle_q <= middle_mem[rd.addr];
			end
		end
	end

	assign rd_upper  = rd_upper_q;
	assign rd_middle = rd_middle_q;

endmodule

`default_nettype wire

>>> design/sobel_prewitt_edge_magnitude.sv
// Top level of the 3x3 Sobel/Prewitt edge magnitude filter.
// Depends on spem_pkg and spem_line_store.
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] pixel_value
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata edge/row/column, tlast frame_last
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One pixel per clock while m_axis_tready keeps the stages moving; a result is
// presented on m_axis once its triggering pixel has passed the line store read,
// window, gradient and magnitude registers.
// The registered line store read sets the first stage; every stage holds while
// the one after it is full and stalled, and s_axis_tready follows the stage chain.
// Reset clears counters, window, stage valids and configuration registers;
// line stores need no clearing: their unwritten entries only feed border results.
`default_nettype none

module sobel_prewitt_edge_magnitude
	import spem_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel_value
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // edge_value, out_row, out_column
	output logic                        m_axis_tlast,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data
);

	function automatic logic signed [GRAD_W-1:0] sx(input logic [PIX_W-1:0] p);
		sx = $signed(GRAD_W'(p));
	endfunction

	// configuration
	logic             mode_q;
	logic [COL_W-1:0] w_m1_q, w_m2_q;
	logic [ROW_W-1:0] h_m1_q, h_m2_q;
	logic [WDIM_W-1:0] w_clamp;
	logic [HDIM_W-1:0] h_clamp;
	logic             cfg_acc;
	logic             restart;

	// raster position
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// stage control
	logic acc, rdy_out, s3_free, s2_free, s1_free, mv1;
	logic s1_v_q, s2_v_q, s3_v_q, out_v_q;

	// stage payloads
	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1, emit_s2, emit_s3;
	logic             inner_s1, inner_s2, inner_s3;
	logic             last_s1, last_s2, last_s3;
	logic [ROW_W-1:0] pr_s1, pr_s2, pr_s3;
	logic [COL_W-1:0] pc_s1, pc_s2, pc_s3;
	logic signed [GRAD_W-1:0] gx_s3, gy_s3;

	// window, row 0 on top, column 2 newest
	logic [PIX_W-1:0] win_q [3][3];

	logic [PIX_W-1:0] edge_q;
	logic [ROW_W-1:0] orow_q;
	logic [COL_W-1:0] ocol_q;
	logic             olast_q;

	// accept-side decode
	logic             emit_d, inner_d, last_d;
	logic [ROW_W-1:0] pr_d;
	logic [COL_W-1:0] pc_d;

	// gradient and magnitude
	logic signed [GRAD_W-1:0] cl, cr, ct, cb, gx_d, gy_d;
	logic [GRAD_W-1:0] ax, ay;
	logic [MAG_W-1:0]  mag;
	logic [PIX_W-1:0]  edge_d;

	ls_rd_t           ls_rd;
	ls_wr_t           ls_wr;
	logic [PIX_W-1:0] rd_upper, rd_middle;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign restart   = cfg_acc && ((cfg_index == CFG_IMAGE_WIDTH) ||
		(cfg_index == CFG_IMAGE_HEIGHT));

	always_comb begin
		if (WDIM_W'(cfg_data) > WDIM_W'(MAX_WIDTH)) begin
			w_clamp = WDIM_W'(MAX_WIDTH);
		end else if (cfg_data < CFG_W'(3)) begin
			w_clamp = WDIM_W'(3);
		end else begin
			w_clamp = WDIM_W'(cfg_data);
		end
		if (HDIM_W'(cfg_data) > HDIM_W'(MAX_HEIGHT)) begin
			h_clamp = HDIM_W'(MAX_HEIGHT);
		end else if (cfg_data < CFG_W'(3)) begin
			h_clamp = HDIM_W'(3);
		end else begin
			h_clamp = HDIM_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			w_m1_q <= COL_W'(WIDTH_RST - 1);
			w_m2_q <= COL_W'(WIDTH_RST - 2);
			h_m1_q <= ROW_W'(HEIGHT_RST - 1);
			h_m2_q <= ROW_W'(HEIGHT_RST - 2);
		end else if (cfg_acc) begin
			unique case (cfg_index)
				CFG_EDGE_MODE: begin
					mode_q <= cfg_data[0];
				end
				CFG_IMAGE_WIDTH: begin
					w_m1_q <= COL_W'(w_clamp - WDIM_W'(1));
					w_m2_q <= COL_W'(w_clamp - WDIM_W'(2));
				end
				CFG_IMAGE_HEIGHT: begin
					h_m1_q <= ROW_W'(h_clamp - HDIM_W'(1));
					h_m2_q <= ROW_W'(h_clamp - HDIM_W'(2));
				end
				default: begin
				end
			endcase
		end
	end

	// stage chain; a non-emitting item leaves the last stage without a beat
	assign rdy_out       = !out_v_q || m_axis_tready;
	assign s3_free       = !s3_v_q || !emit_s3 || rdy_out;
	assign s2_free       = !s2_v_q || s3_free;
	assign s1_free       = !s1_v_q || s2_free;
	assign s_axis_tready = s1_free;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign mv1           = s1_v_q && s2_free;

	// result position: one row plus one pixel behind the incoming pixel
	always_comb begin
		if (col_q != '0) begin
			emit_d = (row_q != '0);
			pr_d   = row_q - ROW_W'(1);
			pc_d   = col_q - COL_W'(1);
		end else begin
			emit_d = (row_q >= ROW_W'(2));
			pr_d   = row_q - ROW_W'(2);
			pc_d   = w_m1_q;
		end
		inner_d = (pr_d != '0) && (pr_d <= h_m2_q) && (pc_d != '0) && (pc_d <= w_m2_q);
		last_d  = (col_q == w_m1_q) && (row_q == h_m1_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q == w_m1_q) begin
				col_q <= '0;
				row_q <= (row_q == h_m1_q) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	assign ls_rd.en     = acc;
	assign ls_rd.addr   = col_q;
	assign ls_wr.en     = mv1;
	assign ls_wr.addr   = col_s1;
	assign ls_wr.upper  = rd_middle;
	assign ls_wr.middle = pix_s1;

	spem_line_store u_line_store (
		.clk       (clk),
		.rd        (ls_rd),
		.wr        (ls_wr),
		.rd_upper  (rd_upper),
		.rd_middle (rd_middle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			s3_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_v_q <= acc;
			end
			if (s2_free) begin
				s2_v_q <= s1_v_q;
			end
			if (s3_free) begin
				s3_v_q <= s2_v_q;
			end
			if (rdy_out) begin
				out_v_q <= s3_v_q && emit_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1   <= s_axis_tdata;
			col_s1   <= col_q;
			emit_s1  <= emit_d;
			inner_s1 <= inner_d;
			last_s1  <= last_d;
			pr_s1    <= pr_d;
			pc_s1    <= pc_d;
		end
		if (s2_free) begin
			emit_s2  <= emit_s1;
			inner_s2 <= inner_s1;
			last_s2  <= last_s1;
			pr_s2    <= pr_s1;
			pc_s2    <= pc_s1;
		end
		if (s3_free) begin
			emit_s3  <= emit_s2;
			inner_s3 <= inner_s2;
			last_s3  <= last_s2;
			pr_s3    <= pr_s2;
			pc_s3    <= pc_s2;
			gx_s3    <= gx_d;
			gy_s3    <= gy_d;
		end
		if (rdy_out && s3_v_q && emit_s3) begin
			edge_q  <= edge_d;
			orow_q  <= pr_s3;
			ocol_q  <= pc_s3;
			olast_q <= last_s3;
		end
	end

	// shift the window as the item leaves the memory stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (mv1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_upper;
			win_q[1][2] <= rd_middle;
			win_q[2][2] <= pix_s1;
		end
	end

	// centre weight 2 for Sobel, 1 for Prewitt
	always_comb begin
		cl = mode_q ? sx(win_q[1][0]) : (sx(win_q[1][0]) <<< 1);
		cr = mode_q ? sx(win_q[1][2]) : (sx(win_q[1][2]) <<< 1);
		ct = mode_q ? sx(win_q[0][1]) : (sx(win_q[0][1]) <<< 1);
		cb = mode_q ? sx(win_q[2][1]) : (sx(win_q[2][1]) <<< 1);
		gx_d = sx(win_q[0][0]) + cl + sx(win_q[2][0])
			- sx(win_q[0][2]) - cr - sx(win_q[2][2]);
		gy_d = sx(win_q[0][0]) + ct + sx(win_q[0][2])
			- sx(win_q[2][0]) - cb - sx(win_q[2][2]);
	end

	always_comb begin
		ax  = gx_s3[GRAD_W-1] ? GRAD_W'(-gx_s3) : GRAD_W'(gx_s3);
		ay  = gy_s3[GRAD_W-1] ? GRAD_W'(-gy_s3) : GRAD_W'(gy_s3);
		mag = MAG_W'(ax) + MAG_W'(ay);
		if (!inner_s3) begin
			edge_d = '0;
		end else if (mag > MAG_W'(EDGE_MAX)) begin
			edge_d = PIX_W'(EDGE_MAX);
		end else begin
			edge_d = mag[PIX_W-1:0];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, COORD_W'(ocol_q), COORD_W'(orow_q), edge_q};

endmodule

`default_nettype wire

>>> design/spem_checker.sv
// Port-level checks on the result stream of the edge magnitude top level.
// Depends on spem_pkg; attached to the top level by the bind below.
`default_nettype none

module spem_checker
	import spem_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   m_axis_tlast
);

	logic [PIX_W-1:0]   edge_f;
	logic [COORD_W-1:0] row_f, col_f;

	assign edge_f = m_axis_tdata[EDGE_LSB +: PIX_W];
	assign row_f  = m_axis_tdata[ROW_LSB +: COORD_W];
	assign col_f  = m_axis_tdata[COL_LSB +: COORD_W];

	// hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// first row and first column lie on the border
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (row_f == '0 || col_f == '0) |-> edge_f == '0)
		else $error("nonzero edge on top or left border");

	// the last beat of a frame sits at an inner position
	a_last_inner: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> row_f != '0 && col_f != '0)
		else $error("frame end marked on a border position");

endmodule

bind sobel_prewitt_edge_magnitude spem_checker u_spem_checker (.*);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for sobel_prewitt_edge_magnitude: streams grey frames of many sizes and modes,
// predicts every edge beat with a behavioral 3x3 filter and compares it field by field.
// Depends on spem_pkg and the design sources.

module tb;
	import spem_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0]   mag;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
	} edge_beat_t;

	typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_DARK, PIX_BRIGHT} pix_style_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
	localparam int PIXEL_GOAL    = 450;
	localparam int SETTLE_CYCLES = 12;
	localparam int RESET_CYCLES  = 9;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [PIX_W-1:0]       s_axis_tdata = '0;    // [7:0] pixel_value
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] edge_value, [18:8] out_row,
	                                              // [29:19] out_column, [31:30] zero
	logic                   m_axis_tlast;         // frame_last
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_EDGE_MODE;
	logic [CFG_W-1:0]       cfg_data = '0;

	// filter state kept in step with accepted pixels
	logic [PIX_W-1:0] upper_rows [MAX_WIDTH];
	logic [PIX_W-1:0] middle_rows [MAX_WIDTH];
	logic [PIX_W-1:0] win [3][3];
	int unsigned      row_pos = 0;
	int unsigned      col_pos = 0;
	logic             mode_reg = 1'b0;
	logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_RST);
	logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_RST);
	edge_beat_t       edge_expect_q[$];

	int mismatch_count = 0;
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;
	int sink_hold = 0;

	sobel_prewitt_edge_magnitude uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("tb failed");
		$finish;
	end

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void predict_edge(input logic [PIX_W-1:0] pix);
		int unsigned w, h, r, c, pr, pc;
		int          k, gx, gy, mag;
		int          px [3][3];
		logic [PIX_W-1:0] top, mid;
		bit          emit, last;
		edge_beat_t  beat;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		r = row_pos;
		c = col_pos;
		top = upper_rows[c];
		mid = middle_rows[c];
		upper_rows[c] = mid;
		middle_rows[c] = pix;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = pix;
		// the result sits one row and one pixel behind the incoming pixel
		if (c >= 1) begin
			emit = r >= 1;
			pr = r - 1;
			pc = c - 1;
		end else begin
			emit = r >= 2;
			pr = r - 2;
			pc = w - 1;
		end
		last = (c >= w - 1) && (r >= h - 1);
		if (c >= w - 1) begin
			col_pos = 0;
			row_pos = (r >= h - 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
		if (!emit)
			return;
		mag = 0;
		if (pr >= 1 && pr <= h - 2 && pc >= 1 && pc <= w - 2) begin
			foreach (px[i, j])
				px[i][j] = int'(win[i][j]);
			k = mode_reg ? 1 : 2;
			gx = px[0][0] + k * px[1][0] + px[2][0] - px[0][2] - k * px[1][2] - px[2][2];
			gy = px[0][0] + k * px[0][1] + px[0][2] - px[2][0] - k * px[2][1] - px[2][2];
			mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
			if (mag > EDGE_MAX)
				mag = EDGE_MAX;
		end
		beat.mag = PIX_W'(mag);
		beat.row = COORD_W'(pr);
		beat.col = COORD_W'(pc);
		beat.last = last;
		edge_expect_q.push_back(beat);
	endfunction

	task automatic flag_beat(input string what, input edge_beat_t want, input edge_beat_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s at %0t: want mag %0d row %0d col %0d last %0b, %s",
				what, $realtime, want.mag, want.row, want.col, want.last,
				$sformatf("got mag %0d row %0d col %0d last %0b",
					got.mag, got.row, got.col, got.last));
	endtask

	// predict on pixel beats, check on edge beats
	always @(posedge clk) begin
		edge_beat_t got, want;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			predict_edge(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.mag = m_axis_tdata[EDGE_LSB +: PIX_W];
			got.row = m_axis_tdata[ROW_LSB +: COORD_W];
			got.col = m_axis_tdata[COL_LSB +: COORD_W];
			got.last = m_axis_tlast;
			if (edge_expect_q.size() == 0) begin
				flag_beat("unexpected beat", '0, got);
			end else begin
				want = edge_expect_q.pop_front();
				if (got.mag !== want.mag || got.row !== want.row ||
						got.col !== want.col || got.last !== want.last)
					flag_beat("beat mismatch", want, got);
			end
		end
	end

	// sink: random stalls, or one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
				m_axis_tready <= 1'b1;
			end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_pixels(input int count, input pix_style_t style);
		logic [PIX_W-1:0] pix;
		for (int n = 0; n < count; n++) begin
			case (style)
				PIX_EXTREME: pix = $urandom_range(0, 1) ? {PIX_W{1'b1}} : '0;
				PIX_DARK:    pix = PIX_W'($urandom_range(0, 40));
				PIX_BRIGHT:  pix = PIX_W'($urandom_range(200, 255));
				default:     pix = PIX_W'($urandom);
			endcase
			send_pixel(pix);
		end
	endtask

	// drop valid, wait out every expected beat, then let the pipeline settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (edge_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_EDGE_MODE: mode_reg = val[0];
			CFG_IMAGE_WIDTH: begin
				width_reg = val;
				row_pos = 0;
				col_pos = 0;
			end
			CFG_IMAGE_HEIGHT: begin
				height_reg = val;
				row_pos = 0;
				col_pos = 0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_size(input int typical_max);
		case ($urandom_range(0, 15))
			0:       return CFG_W'($urandom_range(0, 2));
			1:       return CFG_W'($urandom_range(MAX_WIDTH + 1, 4095));
			2:       return CFG_W'(MAX_WIDTH);
			default: return CFG_W'($urandom_range(3, typical_max));
		endcase
	endfunction

	// power-up geometry: 640 wide rows, row 0 border results once row 1 starts
	task automatic test_reset_geometry();
		send_pixels(WIDTH_RST + 20, PIX_RANDOM);
		drain();
	endtask

	// smallest frames: saturated Sobel edge, then clamped sizes with an exact Prewitt value
	task automatic test_kernel_corners();
		logic [PIX_W-1:0] bar [9] = '{255, 0, 0, 255, 0, 0, 255, 0, 0};
		logic [PIX_W-1:0] ramp [9] = '{10, 20, 30, 40, 50, 60, 70, 80, 90};
		write_reg(CFG_IMAGE_WIDTH, 12'd3);
		write_reg(CFG_IMAGE_HEIGHT, 12'd3);
		write_reg(CFG_EDGE_MODE, 12'd0);
		foreach (bar[i])
			send_pixel(bar[i]);
		drain();
		write_reg(CFG_EDGE_MODE, 12'hFFF);
		write_reg(CFG_IMAGE_WIDTH, 12'd2);
		write_reg(CFG_IMAGE_HEIGHT, 12'd0);
		foreach (ramp[i])
			send_pixel(ramp[i]);
		drain();
	endtask

	// oversized width clamps to the widest row: no beat before the second row
	task automatic test_widest_row();
		write_reg(CFG_EDGE_MODE, 12'd0);
		write_reg(CFG_IMAGE_WIDTH, 12'hFFF);
		write_reg(CFG_IMAGE_HEIGHT, 12'd3);
		send_pixels(40, PIX_RANDOM);
		drain();
	endtask

	// oversized height clamps high: narrow rows keep counting without a wrap
	task automatic test_tallest_frame();
		write_reg(CFG_IMAGE_WIDTH, 12'd3);
		write_reg(CFG_IMAGE_HEIGHT, 12'd4095);
		send_pixels(60, PIX_EXTREME);
		drain();
	endtask

	// random settings, whole frames for small sizes, partial frames otherwise
	task automatic test_random_settings();
		int         sent, count;
		int unsigned w, h;
		pix_style_t style;
		sent = 0;
		while (sent < PIXEL_GOAL) begin
			src_idle_on = $urandom_range(0, 3) != 0;
			snk_idle_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 1))
				write_reg(CFG_EDGE_MODE, CFG_W'($urandom));
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_IMAGE_WIDTH, pick_size(12));
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_IMAGE_HEIGHT, pick_size(7));
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_SPARE_IDX, CFG_W'($urandom));
			w = clamp_dim(width_reg, MAX_WIDTH);
			h = clamp_dim(height_reg, MAX_HEIGHT);
			if (w * h <= 150 && $urandom_range(0, 3) != 0)
				count = w * h * $urandom_range(1, 3);
			else
				count = $urandom_range(1, 150);
			style = pix_style_t'($urandom_range(0, 3));
			send_pixels(count, style);
			sent += count;
			drain();
		end
	endtask

	// hold the sink off long enough to back up the pipeline into the input
	task automatic test_output_stall();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		write_reg(CFG_IMAGE_WIDTH, 12'd8);
		write_reg(CFG_IMAGE_HEIGHT, 12'd8);
		sink_hold = 400;
		send_pixels(200, PIX_RANDOM);
		drain();
	endtask

	task automatic test_full_rate();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		write_reg(CFG_EDGE_MODE, 12'd1);
		write_reg(CFG_IMAGE_WIDTH, 12'd16);
		write_reg(CFG_IMAGE_HEIGHT, 12'd6);
		send_pixels(2 * 16 * 6, PIX_DARK);
		drain();
	endtask

	initial begin
		foreach (upper_rows[i]) begin
			upper_rows[i] = '0;
			middle_rows[i] = '0;
		end
		foreach (win[i, j])
			win[i][j] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_kernel_corners();
		test_widest_row();
		test_tallest_frame();
		test_random_settings();
		test_output_stall();
		test_full_rate();
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
